// File: rtl/vpe_pkg.sv
package vpe_pkg;

  localparam int GROUP_BITS     = 7;
  localparam int MAX_ALIGN      = 64;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int VALUE_BITS_DEF = 64;
  localparam int QUEUE_DEPTH    = 2;

  localparam int CMD_W   = 2;
  localparam int ALIGN_W = 7;
  localparam int CNT_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 32;

  localparam logic [CMD_W-1:0] CMD_VARINT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RAW    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALIGN  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PAD    = 2'd3;

  localparam logic [1:0] KIND_VARINT = 2'd0;
  localparam logic [1:0] KIND_RAW    = 2'd1;
  localparam logic [1:0] KIND_PAD    = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [CNT_W-1:0]   count;
    logic [ALIGN_W-1:0] max_align;
  } job_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/vpe_cmd_if.sv
interface vpe_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] value;
  logic [6:0]  alignment;
  logic [5:0]  pad_count;

  modport source (output valid, cmd, value, alignment, pad_count, input ready);
  modport sink (input valid, cmd, value, alignment, pad_count, output ready);
endinterface

// File: rtl/vpe_byte_if.sv
interface vpe_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [31:0] byte_position;
  logic [6:0]  max_alignment_seen;
  logic        last;

  modport source (output valid, out_byte, byte_position, max_alignment_seen, last,
                  input ready);
  modport sink (input valid, out_byte, byte_position, max_alignment_seen, last,
                output ready);
endinterface

// File: rtl/vpe_front.sv
module vpe_front #(
  parameter int VALUE_BITS = vpe_pkg::VALUE_BITS_DEF,
  localparam int SHIFT_W =
    ((VALUE_BITS + vpe_pkg::GROUP_BITS - 1) / vpe_pkg::GROUP_BITS) * vpe_pkg::GROUP_BITS
) (
  input  logic              clk,
  input  logic              rst,
  vpe_cmd_if.sink           req,
  input  vpe_pkg::q_status_t q_stat,
  output logic              push,
  output vpe_pkg::job_ctl_t push_ctl,
  output logic [SHIFT_W-1:0] push_data
);
  import vpe_pkg::*;

  localparam int NGROUPS = SHIFT_W / GROUP_BITS;
  localparam int GRP_W   = $clog2(NGROUPS + 1);

  // low offset bits only: enough for padding up to the largest alignment
  logic [CNT_W-1:0]   off_lo;
  logic [ALIGN_W-1:0] largest;

  logic [ALIGN_W-1:0] largest_next;
  logic [SHIFT_W-1:0] ext;
  logic [SHIFT_W-1:0] varint_data;
  logic [GRP_W-1:0]   groups;
  logic               align_ok;
  logic [CNT_W-1:0]   amask;
  logic [CNT_W-1:0]   need;
  logic               accept;

  assign req.ready = !q_stat.full;
  assign accept    = req.valid && req.ready;

  always_comb begin
    ext    = SHIFT_W'(req.value[VALUE_BITS-1:0]);
    groups = GRP_W'(1);
    for (int g = 1; g < NGROUPS; g++) begin
      if (ext[g*GROUP_BITS +: GROUP_BITS] != '0) groups = GRP_W'(g + 1);
    end
    // most significant group lands at the top of the shifter
    varint_data = ext << (GROUP_BITS * (NGROUPS - int'(groups)));

    align_ok = (req.alignment >= 7'd2) && (int'(req.alignment) <= MAX_ALIGN) &&
               ((req.alignment & (req.alignment - 7'd1)) == 7'd0);
    amask    = CNT_W'(req.alignment - 7'd1);
    need     = (CNT_W'(0) - off_lo) & amask;

    largest_next = largest;
    if ((req.cmd == CMD_ALIGN || req.cmd == CMD_PAD) && align_ok &&
        req.alignment > largest) begin
      largest_next = req.alignment;
    end

    push_ctl.max_align = largest_next;
    unique case (req.cmd)
      CMD_VARINT: begin
        push_ctl.kind  = KIND_VARINT;
        push_ctl.count = CNT_W'(groups);
        push_data      = varint_data;
      end
      CMD_RAW: begin
        push_ctl.kind  = KIND_RAW;
        push_ctl.count = CNT_W'(1);
        push_data      = SHIFT_W'(req.value[BYTE_W-1:0]);
      end
      CMD_ALIGN: begin
        push_ctl.kind  = KIND_PAD;
        push_ctl.count = align_ok ? need : '0;
        push_data      = '0;
      end
      CMD_PAD: begin
        push_ctl.kind  = KIND_PAD;
        push_ctl.count = req.pad_count;
        push_data      = '0;
      end
    endcase
  end

  // commands with no bytes only update state
  assign push = accept && (push_ctl.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      off_lo  <= '0;
      largest <= ALIGN_W'(1);
    end else if (accept) begin
      off_lo  <= off_lo + push_ctl.count;
      largest <= largest_next;
    end
  end

endmodule

// File: rtl/vpe_fifo.sv
module vpe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = vpe_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output vpe_pkg::q_status_t stat
);
  import vpe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;

  assign stat.full  = (fill == CNT_QW'(DEPTH));
  assign stat.empty = (fill == '0);
  assign rdata      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      fill <= fill + CNT_QW'(1);
      else if (pop && !push) fill <= fill - CNT_QW'(1);
    end
  end

endmodule

// File: rtl/vpe_back.sv
module vpe_back #(
  parameter int VALUE_BITS  = vpe_pkg::VALUE_BITS_DEF,
  parameter int OFFSET_BITS = vpe_pkg::OFFSET_BITS_DEF,
  localparam int SHIFT_W =
    ((VALUE_BITS + vpe_pkg::GROUP_BITS - 1) / vpe_pkg::GROUP_BITS) * vpe_pkg::GROUP_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         pad_byte,
  input  vpe_pkg::q_status_t q_stat,
  input  vpe_pkg::job_ctl_t  job_ctl,
  input  logic [SHIFT_W-1:0] job_data,
  output logic               pop,
  vpe_byte_if.source         emit
);
  import vpe_pkg::*;

  logic                   busy;
  logic [1:0]             kind;
  logic [CNT_W-1:0]       remain;
  logic [ALIGN_W-1:0]     max_align;
  logic [SHIFT_W-1:0]     sh;
  logic [OFFSET_BITS-1:0] stream_offset;

  logic                   out_valid;
  logic [BYTE_W-1:0]      out_byte;
  logic [POS_W-1:0]       byte_position;
  logic [ALIGN_W-1:0]     out_align;
  logic                   out_last;

  logic                   advance;
  logic                   fire;
  logic [BYTE_W-1:0]      byte_next;

  assign advance = !out_valid || emit.ready;
  assign fire    = busy && advance;
  assign pop     = !busy && !q_stat.empty;

  always_comb begin
    unique case (kind)
      KIND_VARINT: byte_next = {remain != CNT_W'(1), sh[SHIFT_W-1 -: GROUP_BITS]};
      KIND_RAW:    byte_next = sh[BYTE_W-1:0];
      default:     byte_next = pad_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      out_valid     <= 1'b0;
      stream_offset <= '0;
    end else begin
      if (fire) begin
        out_valid     <= 1'b1;
        stream_offset <= stream_offset + OFFSET_BITS'(1);
        if (remain == CNT_W'(1)) busy <= 1'b0;
      end else if (advance) begin
        out_valid <= 1'b0;
      end
      if (pop) busy <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind      <= job_ctl.kind;
      remain    <= job_ctl.count;
      max_align <= job_ctl.max_align;
      sh        <= job_data;
    end else if (fire) begin
      remain <= remain - CNT_W'(1);
      sh     <= sh << GROUP_BITS;
    end
    if (fire) begin
      out_byte      <= byte_next;
      byte_position <= POS_W'(stream_offset);
      out_align     <= max_align;
      out_last      <= (remain == CNT_W'(1));
    end
  end

  assign emit.valid              = out_valid;
  assign emit.out_byte           = out_byte;
  assign emit.byte_position      = byte_position;
  assign emit.max_alignment_seen = out_align;
  assign emit.last               = out_last;

endmodule

// File: rtl/varint_and_padding_byte_emitter_unit.sv
// channel | dir | beat contents
// req     | in  | cmd, value, alignment, pad_count
// emit    | out | out_byte, byte_position, max_alignment_seen, last
// cfg     | in  | cfg_we / cfg_wdata -> pad byte
//
// The front stage accepts a command and queues a job if it has bytes; the back stage
// loads one job at a time and emits its bytes in turn, taking a new job only after the
// last byte of the current one has been emitted. The single output byte port sets the rate.
// rst is synchronous; it resets the offset, queue and alignment record.
// A 2-entry job queue lets the front keep accepting while emit is stalled, until it fills.
module varint_and_padding_byte_emitter_unit #(
  parameter int OFFSET_BITS = vpe_pkg::OFFSET_BITS_DEF,
  parameter int VALUE_BITS  = vpe_pkg::VALUE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       cfg_we,
  input logic [7:0] cfg_wdata,
  vpe_cmd_if.sink   req,
  vpe_byte_if.source emit
);
  import vpe_pkg::*;

  localparam int SHIFT_W = ((VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS) * GROUP_BITS;
  localparam int Q_W     = $bits(job_ctl_t) + SHIFT_W;

  logic [BYTE_W-1:0]  pad_byte;
  q_status_t          q_stat;
  logic               push;
  logic               pop;
  job_ctl_t           push_ctl;
  job_ctl_t           head_ctl;
  logic [SHIFT_W-1:0] push_data;
  logic [SHIFT_W-1:0] head_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_byte <= '0;
    end else if (cfg_we) begin
      pad_byte <= cfg_wdata;
    end
  end

  vpe_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .q_stat    (q_stat),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_data (push_data)
  );

  vpe_fifo #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_ctl, push_data}),
    .pop   (pop),
    .rdata ({head_ctl, head_data}),
    .stat  (q_stat)
  );

  vpe_back #(.VALUE_BITS(VALUE_BITS), .OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .pad_byte (pad_byte),
    .q_stat   (q_stat),
    .job_ctl  (head_ctl),
    .job_data (head_data),
    .pop      (pop),
    .emit     (emit)
  );

  // back-to-back beats carry consecutive stream offsets
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (emit.valid && emit.ready) ##1 emit.valid |->
      emit.byte_position == 32'($past(emit.byte_position) + 32'd1))
    else $error("byte_position did not advance by one");

  // the alignment record never shrinks
  a_align_mono: assert property (@(posedge clk) disable iff (rst)
    (emit.valid && emit.ready) ##1 emit.valid |->
      emit.max_alignment_seen >= $past(emit.max_alignment_seen))
    else $error("max_alignment_seen decreased");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!q_stat.full || pop))
    else $error("job queue overflow");

  a_align_nonzero: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> emit.max_alignment_seen != '0)
    else $error("alignment record is zero");

endmodule

// File: bench/emit_stream_checker.sv
`timescale 1ns / 100ps
module emit_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  vpe_cmd_if         req,
  vpe_byte_if        emit,
  output int         errors,
  output int         pending,
  output int         cmds_seen,
  output int         bytes_seen
);
  import vpe_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [POS_W-1:0]   pos;
    logic [ALIGN_W-1:0] max_align;
    logic               last;
  } stream_byte_t;

  stream_byte_t       byte_fifo[$];
  logic [7:0]         pad_val;
  logic [POS_W-1:0]   next_pos;
  logic [ALIGN_W-1:0] align_record;

  function automatic logic align_valid(input logic [ALIGN_W-1:0] a);
    return a >= 2 && a <= MAX_ALIGN && (a & (a - 7'd1)) == 0;
  endfunction

  // Expand one command into the bytes it appends to the stream.
  task automatic predict_cmd(input logic [CMD_W-1:0] c, input logic [63:0] v,
                             input logic [ALIGN_W-1:0] a, input logic [CNT_W-1:0] n);
    logic [7:0]         bytes[$];
    logic [7:0]         vb;
    int                 groups;
    logic [ALIGN_W-1:0] need;
    stream_byte_t       eb;
    case (c)
      CMD_VARINT: begin
        groups = 1;
        while (groups < 10 && (v >> (GROUP_BITS * groups)) != 0) groups++;
        // most significant group first, continuation bit on all but the last
        for (int k = groups - 1; k >= 0; k--) begin
          vb    = {k != 0, 7'(v >> (GROUP_BITS * k))};
          bytes = {bytes, vb};
        end
      end
      CMD_RAW: bytes = {bytes, v[7:0]};
      CMD_ALIGN: begin
        if (align_valid(a)) begin
          need = 7'(0 - next_pos) & (a - 7'd1);
          repeat (need) bytes = {bytes, pad_val};
          if (a > align_record) align_record = a;
        end
      end
      default: begin
        repeat (n) bytes = {bytes, pad_val};
        if (align_valid(a) && a > align_record) align_record = a;
      end
    endcase
    foreach (bytes[i]) begin
      eb.data      = bytes[i];
      eb.pos       = next_pos;
      eb.max_align = align_record;
      eb.last      = (i == bytes.size() - 1);
      byte_fifo    = {byte_fifo, eb};
      next_pos++;
    end
  endtask

  task automatic check_beat();
    stream_byte_t eb;
    bytes_seen++;
    if (byte_fifo.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected beat byte %02h pos %0d", $realtime, emit.out_byte,
                 emit.byte_position);
    end else begin
      eb = byte_fifo.pop_front();
      if (emit.out_byte !== eb.data || emit.byte_position !== eb.pos ||
          emit.max_alignment_seen !== eb.max_align || emit.last !== eb.last) begin
        errors++;
        if (errors <= 10)
          $display("%0t: exp %02h pos %0d align %0d last %0b, got %02h %0d %0d %0b",
                   $realtime, eb.data, eb.pos, eb.max_align, eb.last, emit.out_byte,
                   emit.byte_position, emit.max_alignment_seen, emit.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_fifo.delete();
      pad_val      = 8'h00;
      next_pos     = '0;
      align_record = 7'd1;
    end else begin
      if (cfg_we) pad_val = cfg_wdata;
      if (req.valid && req.ready) begin
        predict_cmd(req.cmd, req.value, req.alignment, req.pad_count);
        cmds_seen++;
      end
      if (emit.valid && emit.ready) check_beat();
    end
    pending = byte_fifo.size();
  end
endmodule

// File: bench/tb_varint_and_padding_byte_emitter_unit.sv
`timescale 1ns / 100ps
module tb_varint_and_padding_byte_emitter_unit;
  import vpe_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       src_gaps = 1'b1;
  logic       sink_gaps = 1'b1;
  logic       stall_req = 1'b0;
  int         errors, pending, cmds_seen, bytes_seen;

  vpe_cmd_if  req_if ();
  vpe_byte_if emit_if ();

  varint_and_padding_byte_emitter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .emit      (emit_if)
  );

  emit_stream_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req_if),
    .emit       (emit_if),
    .errors     (errors),
    .pending    (pending),
    .cmds_seen  (cmds_seen),
    .bytes_seen (bytes_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Output side: random back-pressure plus one long hold-off on request.
  initial begin
    emit_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        emit_if.ready <= 1'b0;
        repeat (120) @(negedge clk);
        stall_req = 1'b0;
      end
      emit_if.ready <= !(sink_gaps && $urandom_range(99, 0) < 7);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly powers of two (plus 0), sometimes any 7-bit value.
  function automatic logic [ALIGN_W-1:0] pick_align();
    int k;
    if ($urandom_range(99, 0) < 80) begin
      k = $urandom_range(7, 0);
      return (k == 7) ? 7'd0 : 7'(1 << k);
    end
    return 7'($urandom_range(127, 0));
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [63:0] v,
                          input logic [ALIGN_W-1:0] a, input logic [CNT_W-1:0] n);
    @(negedge clk);
    while (src_gaps && $urandom_range(99, 0) < 7) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= c;
    req_if.value     <= v;
    req_if.alignment <= a;
    req_if.pad_count <= n;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic send_random();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 35)
      send_cmd(CMD_VARINT, rand64() >> $urandom_range(63, 0), pick_align(),
               6'($urandom_range(63, 0)));
    else if (roll < 55)
      send_cmd(CMD_RAW, rand64(), pick_align(), 6'($urandom_range(63, 0)));
    else if (roll < 78)
      send_cmd(CMD_ALIGN, rand64(), pick_align(), 6'($urandom_range(63, 0)));
    else
      send_cmd(CMD_PAD, rand64(), pick_align(),
               6'(($urandom_range(9, 0) == 0) ? $urandom_range(63, 0)
                                              : $urandom_range(12, 0)));
  endtask

  // Drop valid and wait until every predicted beat has come out.
  task automatic drain_stream();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_pad(input logic [7:0] b);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    req_if.valid     = 1'b0;
    req_if.cmd       = CMD_VARINT;
    req_if.value     = '0;
    req_if.alignment = '0;
    req_if.pad_count = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_pad(8'h00);
    send_cmd(CMD_VARINT, 64'd0, 7'd0, 6'd0);
    send_cmd(CMD_VARINT, 64'd127, 7'd0, 6'd0);
    send_cmd(CMD_VARINT, 64'd128, 7'd0, 6'd0);
    send_cmd(CMD_VARINT, 64'h3FFF, 7'd0, 6'd0);
    send_cmd(CMD_VARINT, 64'h4000, 7'd0, 6'd0);
    send_cmd(CMD_VARINT, '1, '1, '1);
    send_cmd(CMD_VARINT, 64'h8000_0000_0000_0000, 7'd0, 6'd0);
    send_cmd(CMD_RAW, 64'hFFFF_FFFF_FFFF_FF00, 7'd0, 6'd0);
    send_cmd(CMD_RAW, 64'h0000_0000_0000_00FF, 7'd0, 6'd0);
    send_cmd(CMD_ALIGN, 64'd0, 7'd0, 6'd0);
    send_cmd(CMD_ALIGN, 64'd0, 7'd1, 6'd0);
    // record goes up with no bytes emitted
    send_cmd(CMD_PAD, 64'd0, 7'd32, 6'd0);
    send_cmd(CMD_RAW, 64'h01, 7'd0, 6'd0);
    send_cmd(CMD_ALIGN, 64'd0, 7'd2, 6'd0);
    send_cmd(CMD_ALIGN, 64'd0, 7'd64, 6'd0);
    send_cmd(CMD_ALIGN, 64'd0, 7'd64, 6'd0);
    send_cmd(CMD_ALIGN, 64'd0, 7'd3, 6'd0);
    send_cmd(CMD_ALIGN, 64'd0, 7'd127, 6'd0);
    send_cmd(CMD_PAD, 64'd0, 7'd6, 6'd63);
    send_cmd(CMD_PAD, 64'd0, 7'd0, 6'd5);
    send_cmd(CMD_PAD, 64'd0, 7'd80, 6'd3);
    send_cmd(CMD_ALIGN, 64'd0, 7'd8, 6'd0);
    drain_stream();

    write_pad(8'hFF);
    repeat (20) send_random();
    drain_stream();

    // long hold-off on the output while commands keep coming, then a gap-free stretch
    write_pad(8'($urandom_range(255, 0)));
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    stall_req = 1'b1;
    repeat (12) send_random();
    repeat (25) send_random();
    drain_stream();

    write_pad(8'($urandom_range(255, 0)));
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    repeat (25) send_random();
    drain_stream();
    repeat (20) @(posedge clk);

    $display("Covered %0d commands and %0d output beats over four pad byte settings,",
             cmds_seen, bytes_seen);
    $display("with random gaps on both channels and one long output hold-off.");
    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
